// ----- rtl/lcdx_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdx_pkg
// Shared types, codes and init tables for the character LCD expander sequencer.
// ----------------------------------------------------------------------------
package lcdx_pkg;

  // request codes
  localparam logic [2:0] CMD_INIT      = 3'd0;
  localparam logic [2:0] CMD_CLEAR     = 3'd1;
  localparam logic [2:0] CMD_CURSOR    = 3'd2;
  localparam logic [2:0] CMD_CHAR      = 3'd3;
  localparam logic [2:0] CMD_BACKLIGHT = 3'd4;

  // work kinds handed from front to back
  localparam logic [1:0] KIND_EMPTY  = 2'd0;  // one result, no byte
  localparam logic [1:0] KIND_SINGLE = 2'd1;  // one backlight byte
  localparam logic [1:0] KIND_BYTE   = 2'd2;  // one command or char, six bytes
  localparam logic [1:0] KIND_INIT   = 2'd3;  // init sequence, 42 bytes

  // expander pins
  localparam logic [7:0] PIN_RS = 8'h80;
  localparam logic [7:0] PIN_EN = 8'h20;
  localparam logic [7:0] PIN_BL = 8'h10;

  // LCD commands
  localparam logic [7:0] LCD_CLEAR   = 8'h01;
  localparam logic [7:0] LCD_DDRAM   = 8'h80;

  // waits in ms
  localparam logic [8:0] WAIT_POWERUP = 9'd260;
  localparam logic [3:0] WAIT_CMD     = 4'd2;
  localparam logic [3:0] WAIT_CLEAR   = 4'd10;

  // strobe phases of one nibble
  localparam logic [1:0] PH_PLAIN  = 2'd0;
  localparam logic [1:0] PH_STROBE = 2'd1;
  localparam logic [1:0] PH_HOLD   = 2'd2;

  localparam logic [3:0] INIT_LAST_NIB = 4'd13;

  typedef struct packed {
    logic [1:0] kind;
    logic       status;  // not-initialized flag, empty kind only
    logic       rs;
    logic       bl;      // backlight bit for the bytes of this word
    logic [7:0] value;
    logic [3:0] wait_after;
  } desc_t;

  // nibbles of the init sequence: 3,3,3,2 then 0x28 0x08 0x01 0x06 0x0C
  function automatic logic [3:0] init_nibble(input logic [3:0] nib);
    logic [3:0] r;
    unique case (nib)
      4'd0, 4'd1, 4'd2: r = 4'h3;
      4'd3, 4'd4:       r = 4'h2;
      4'd5, 4'd7:       r = 4'h8;
      4'd9:             r = 4'h1;
      4'd11:            r = 4'h6;
      4'd13:            r = 4'hC;
      default:          r = 4'h0;
    endcase
    return r;
  endfunction

  // wait after the hold byte of each init nibble
  function automatic logic [3:0] init_wait(input logic [3:0] nib);
    logic [3:0] r;
    unique case (nib)
      4'd0:                     r = 4'd5;
      4'd1, 4'd2, 4'd3:         r = 4'd1;
      4'd5, 4'd7, 4'd11, 4'd13: r = WAIT_CMD;
      4'd9:                     r = WAIT_CLEAR;
      default:                  r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/char_lcd_expander_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// char_lcd_expander_sequencer_unit
// HD44780 4-bit request sequencer emitting port expander bytes with ms waits.
// ----------------------------------------------------------------------------
// A request is first written into the queue, and the back sequencer then registers
//   its first result in the output register.
// One result per cycle leaves the output register while work is queued and out_ready is
//   high; a command or character gives six results, init 42, other requests one.
// A two-word queue lets requests be taken while the back end is still busy.
// Reset: synchronous; not initialized, backlight on, queue and output empty.
// ----------------------------------------------------------------------------
module char_lcd_expander_sequencer_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] cmd,
  input  logic [7:0] row,
  input  logic [7:0] col,
  input  logic [7:0] char_code,
  input  logic       light_on,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       byte_valid,
  output logic [7:0] expander_byte,
  output logic [8:0] wait_before_ms,
  output logic [3:0] wait_after_ms,
  output logic       status,
  output logic       last
);

  lcdx_pkg::desc_t front_desc;
  lcdx_pkg::desc_t head;
  logic            push;
  logic            pop;
  logic            full;
  logic            not_empty;

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  lcdx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .char_code (char_code),
    .light_on  (light_on),
    .desc      (front_desc)
  );

  lcdx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (front_desc),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  lcdx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (not_empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .byte_valid     (byte_valid),
    .expander_byte  (expander_byte),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .status         (status),
    .last           (last)
  );

endmodule

// ----- rtl/lcdx_front.sv -----
// ----------------------------------------------------------------------------
// lcdx_front
// Takes requests, tracks init and backlight state, and builds work descriptors.
// ----------------------------------------------------------------------------
module lcdx_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [2:0]     cmd,
  input  logic [7:0]     row,
  input  logic [7:0]     col,
  input  logic [7:0]     char_code,
  input  logic           light_on,
  output lcdx_pkg::desc_t desc
);

  logic       ready_flag;
  logic       light_bit;
  logic       ready_flag_next;
  logic       light_bit_next;
  logic       row_c;
  logic [3:0] col_c;

  assign row_c = (row != 8'd0);
  assign col_c = (col > 8'd15) ? 4'hF : col[3:0];

  always_comb begin
    desc            = '0;
    desc.kind       = lcdx_pkg::KIND_EMPTY;
    desc.bl         = light_bit;
    ready_flag_next = ready_flag;
    light_bit_next  = light_bit;
    if (cmd == lcdx_pkg::CMD_INIT) begin
      if (!ready_flag) begin
        desc.kind       = lcdx_pkg::KIND_INIT;
        ready_flag_next = 1'b1;
      end
    end else if (cmd > lcdx_pkg::CMD_BACKLIGHT) begin
      desc.kind = lcdx_pkg::KIND_EMPTY;
    end else if (!ready_flag) begin
      desc.status = 1'b1;
    end else begin
      unique case (cmd)
        lcdx_pkg::CMD_CLEAR: begin
          desc.kind       = lcdx_pkg::KIND_BYTE;
          desc.value      = lcdx_pkg::LCD_CLEAR;
          desc.wait_after = lcdx_pkg::WAIT_CLEAR;
        end
        lcdx_pkg::CMD_CURSOR: begin
          desc.kind       = lcdx_pkg::KIND_BYTE;
          // col is at most 15, so the add is a plain bit merge
          desc.value      = lcdx_pkg::LCD_DDRAM | {1'b0, row_c, 2'b00, col_c};
          desc.wait_after = lcdx_pkg::WAIT_CMD;
        end
        lcdx_pkg::CMD_CHAR: begin
          desc.kind       = lcdx_pkg::KIND_BYTE;
          desc.rs         = 1'b1;
          desc.value      = char_code;
          desc.wait_after = lcdx_pkg::WAIT_CMD;
        end
        default: begin
          desc.kind      = lcdx_pkg::KIND_SINGLE;
          desc.bl        = light_on;
          light_bit_next = light_on;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_flag <= 1'b0;
      light_bit  <= 1'b1;
    end else if (push) begin
      ready_flag <= ready_flag_next;
      light_bit  <= light_bit_next;
    end
  end

endmodule

// ----- rtl/lcdx_queue.sv -----
// ----------------------------------------------------------------------------
// lcdx_queue
// Two-entry descriptor queue between front and back.
// ----------------------------------------------------------------------------
module lcdx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdx_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output lcdx_pkg::desc_t head
);

  lcdx_pkg::desc_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/lcdx_back.sv -----
// ----------------------------------------------------------------------------
// lcdx_back
// Walks a descriptor nibble by nibble and strobe phase by phase into the
// output register, one expander byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module lcdx_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  lcdx_pkg::desc_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            byte_valid,
  output logic [7:0]      expander_byte,
  output logic [8:0]      wait_before_ms,
  output logic [3:0]      wait_after_ms,
  output logic            status,
  output logic            last
);

  logic [1:0] phase;
  logic [3:0] nib;
  logic       load;
  logic       step;

  logic       r_valid;
  logic [7:0] r_byte;
  logic [8:0] r_wb;
  logic [3:0] r_wa;
  logic       r_status;
  logic       r_last;
  logic [3:0] nib_val;
  logic [7:0] base;
  logic       hold;

  assign load = !out_valid || out_ready;
  assign step = head_valid && load;
  assign pop  = step && r_last;
  assign hold = (phase == lcdx_pkg::PH_HOLD);
  assign base = (head.rs ? lcdx_pkg::PIN_RS : 8'h00) | (head.bl ? lcdx_pkg::PIN_BL : 8'h00);

  always_comb begin
    r_valid  = 1'b1;
    r_byte   = 8'h00;
    r_wb     = 9'd0;
    r_wa     = 4'd0;
    r_status = 1'b0;
    r_last   = 1'b1;
    nib_val  = 4'h0;
    unique case (head.kind)
      lcdx_pkg::KIND_EMPTY: begin
        r_valid  = 1'b0;
        r_status = head.status;
      end
      lcdx_pkg::KIND_SINGLE: begin
        r_byte = head.bl ? lcdx_pkg::PIN_BL : 8'h00;
      end
      lcdx_pkg::KIND_BYTE: begin
        nib_val = nib[0] ? head.value[3:0] : head.value[7:4];
        r_byte  = base | {4'h0, nib_val}
                  | ((phase == lcdx_pkg::PH_STROBE) ? lcdx_pkg::PIN_EN : 8'h00);
        r_last  = nib[0] && hold;
        r_wa    = r_last ? head.wait_after : 4'd0;
      end
      default: begin
        nib_val = lcdx_pkg::init_nibble(nib);
        r_byte  = base | {4'h0, nib_val}
                  | ((phase == lcdx_pkg::PH_STROBE) ? lcdx_pkg::PIN_EN : 8'h00);
        r_wb    = (nib == 4'd0 && phase == lcdx_pkg::PH_PLAIN) ?
                  lcdx_pkg::WAIT_POWERUP : 9'd0;
        r_wa    = hold ? lcdx_pkg::init_wait(nib) : 4'd0;
        r_last  = (nib == lcdx_pkg::INIT_LAST_NIB) && hold;
      end
    endcase
  end

  // sequence position within the current word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lcdx_pkg::PH_PLAIN;
      nib   <= 4'd0;
    end else if (step) begin
      if (r_last) begin
        phase <= lcdx_pkg::PH_PLAIN;
        nib   <= 4'd0;
      end else if (hold) begin
        phase <= lcdx_pkg::PH_PLAIN;
        nib   <= nib + 4'd1;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_valid     <= r_valid;
      expander_byte  <= r_byte;
      wait_before_ms <= r_wb;
      wait_after_ms  <= r_wa;
      status         <= r_status;
      last           <= r_last;
    end
  end

endmodule

// ----- rtl/lcdx_checker.sv -----
// ----------------------------------------------------------------------------
// lcdx_checker
// Port-level checks on the sequencer output stream.
// ----------------------------------------------------------------------------
module lcdx_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       byte_valid,
  input logic [7:0] expander_byte,
  input logic [8:0] wait_before_ms,
  input logic [3:0] wait_after_ms,
  input logic       status,
  input logic       last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(expander_byte) && $stable(last)
      && $stable(byte_valid))
    else $error("output word changed while stalled");

  // an empty result carries no byte and no waits
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> expander_byte == 8'h00 && wait_before_ms == 9'd0
      && wait_after_ms == 4'd0 && last)
    else $error("empty result not clean");

  // not-initialized status only on an empty single result
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !byte_valid && last)
    else $error("status on a byte result");

  // RW stays low, and a strobe byte never ends a request
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !expander_byte[6] && !(expander_byte[5] && last))
    else $error("bad pin pattern");

  // the power-up wait comes only on the first init nibble byte
  a_powerup: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_before_ms != 9'd0 |->
      wait_before_ms == 9'd260 && expander_byte[3:0] == 4'h3 && !expander_byte[5])
    else $error("unexpected wait before");

endmodule

bind char_lcd_expander_sequencer_unit lcdx_checker u_lcdx_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .byte_valid     (byte_valid),
  .expander_byte  (expander_byte),
  .wait_before_ms (wait_before_ms),
  .wait_after_ms  (wait_after_ms),
  .status         (status),
  .last           (last)
);

// ----- tb/tb_char_lcd_expander_sequencer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_expander_sequencer_unit
// Self-checking bench for the LCD request sequencer. Requests from a pending
// queue go to the block, and a predictor expands each one into the expander
// words it should cause. Returned words are checked in order, field by field,
// under random idling on both sides, one long output hold and one drain pause.
// ----------------------------------------------------------------------------
module tb_char_lcd_expander_sequencer_unit;

  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_REQS      = 455;
  localparam int TAIL_REQS        = 60;
  localparam int DRAIN_PAUSE_AT   = 300;
  localparam int LONG_HOLD_AT     = 800;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT       = 4000;
  localparam int SETTLE_CYCLES    = 20;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

  localparam logic [7:0] LCD_FUNC_4BIT    = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_OFF  = 8'h08;
  localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] LCD_ROW1_OFFSET  = 8'h40;
  localparam logic [3:0] NIB_WAKE         = 4'h3;
  localparam logic [3:0] NIB_4BIT         = 4'h2;
  localparam logic [3:0] WAIT_WAKE_FIRST  = 4'd5;
  localparam logic [3:0] WAIT_WAKE        = 4'd1;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] char_code;
    logic       light_on;
    bit         drain_first;  // hold off until every expected word is back
  } lcd_request_t;

  typedef struct {
    logic       byte_valid;
    logic [7:0] expander_byte;
    logic [8:0] wait_before_ms;
    logic [3:0] wait_after_ms;
    logic       status;
    logic       last;
  } lcd_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] cmd = '0;
  logic [7:0] row = '0;
  logic [7:0] col = '0;
  logic [7:0] char_code = '0;
  logic       light_on = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       byte_valid;
  logic [7:0] expander_byte;
  logic [8:0] wait_before_ms;
  logic [3:0] wait_after_ms;
  logic       status;
  logic       last;

  lcd_request_t pending_reqs[$];
  lcd_word_t    expected_words[$];
  lcd_word_t    staged_words[$];
  lcd_request_t offered_req;

  // predictor state
  logic lcd_ready_flag = 1'b0;
  logic backlight_bit  = 1'b1;

  int  send_gap = 0;
  int  recv_stall = 0;
  int  idle_cycles = 0;
  int  reqs_accepted = 0;
  int  words_seen = 0;
  int  mismatches = 0;
  int  inits_sent = 0;
  bit  quiet_tail = 1'b0;
  bit  long_hold_done = 1'b0;

  char_lcd_expander_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .row(row), .col(col), .char_code(char_code), .light_on(light_on),
    .out_valid(out_valid), .out_ready(out_ready),
    .byte_valid(byte_valid), .expander_byte(expander_byte),
    .wait_before_ms(wait_before_ms), .wait_after_ms(wait_after_ms),
    .status(status), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void add_request(logic [2:0] c, logic [7:0] r, logic [7:0] k,
                                      logic [7:0] ch, logic lon);
    lcd_request_t req;
    req = '{c, r, k, ch, lon, 1'b0};
    pending_reqs.push_back(req);
  endfunction

  // one nibble: plain, EN high, EN low
  function automatic void stage_nibble(logic [7:0] base, logic [3:0] nib,
                                       logic [8:0] wb, logic [3:0] wa);
    logic [7:0] plain;
    plain = base | {4'h0, nib};
    staged_words.push_back('{1'b1, plain, wb, 4'd0, 1'b0, 1'b0});
    staged_words.push_back('{1'b1, plain | lcdx_pkg::PIN_EN, 9'd0, 4'd0, 1'b0, 1'b0});
    staged_words.push_back('{1'b1, plain & ~lcdx_pkg::PIN_EN, 9'd0, wa, 1'b0, 1'b0});
  endfunction

  function automatic void stage_lcd_byte(logic [7:0] rs, logic [7:0] value,
                                         logic [3:0] wa);
    logic [7:0] base;
    base = (backlight_bit ? lcdx_pkg::PIN_BL : 8'h00) | rs;
    stage_nibble(base, value[7:4], 9'd0, 4'd0);
    stage_nibble(base, value[3:0], 9'd0, wa);
  endfunction

  function automatic void stage_empty(logic st);
    staged_words.push_back('{1'b0, 8'h00, 9'd0, 4'd0, st, 1'b0});
  endfunction

  // expand one accepted request into its expander words
  function automatic void expand_request(lcd_request_t req);
    logic [7:0] bl_base;
    logic [7:0] row_c;
    logic [7:0] col_c;
    staged_words.delete();
    bl_base = backlight_bit ? lcdx_pkg::PIN_BL : 8'h00;
    if (req.cmd == lcdx_pkg::CMD_INIT) begin
      if (lcd_ready_flag) begin
        stage_empty(1'b0);
      end else begin
        stage_nibble(bl_base, NIB_WAKE, lcdx_pkg::WAIT_POWERUP, WAIT_WAKE_FIRST);
        stage_nibble(bl_base, NIB_WAKE, 9'd0, WAIT_WAKE);
        stage_nibble(bl_base, NIB_WAKE, 9'd0, WAIT_WAKE);
        stage_nibble(bl_base, NIB_4BIT, 9'd0, WAIT_WAKE);
        stage_lcd_byte(8'h00, LCD_FUNC_4BIT, lcdx_pkg::WAIT_CMD);
        stage_lcd_byte(8'h00, LCD_DISPLAY_OFF, lcdx_pkg::WAIT_CMD);
        stage_lcd_byte(8'h00, lcdx_pkg::LCD_CLEAR, lcdx_pkg::WAIT_CLEAR);
        stage_lcd_byte(8'h00, LCD_ENTRY_MODE, lcdx_pkg::WAIT_CMD);
        stage_lcd_byte(8'h00, LCD_DISPLAY_ON, lcdx_pkg::WAIT_CMD);
        lcd_ready_flag = 1'b1;
      end
    end else if (req.cmd > lcdx_pkg::CMD_BACKLIGHT) begin
      stage_empty(1'b0);
    end else if (!lcd_ready_flag) begin
      stage_empty(1'b1);
    end else begin
      case (req.cmd)
        lcdx_pkg::CMD_CLEAR: begin
          stage_lcd_byte(8'h00, lcdx_pkg::LCD_CLEAR, lcdx_pkg::WAIT_CLEAR);
        end
        lcdx_pkg::CMD_CURSOR: begin
          row_c = (req.row > 8'd1) ? 8'd1 : req.row;
          col_c = (req.col > 8'd15) ? 8'd15 : req.col;
          stage_lcd_byte(8'h00,
                         lcdx_pkg::LCD_DDRAM
                           | (col_c + (row_c != 0 ? LCD_ROW1_OFFSET : 8'h00)),
                         lcdx_pkg::WAIT_CMD);
        end
        lcdx_pkg::CMD_CHAR: begin
          stage_lcd_byte(lcdx_pkg::PIN_RS, req.char_code, lcdx_pkg::WAIT_CMD);
        end
        default: begin
          backlight_bit = req.light_on;
          staged_words.push_back('{1'b1, req.light_on ? lcdx_pkg::PIN_BL : 8'h00,
                                   9'd0, 4'd0, 1'b0, 1'b0});
        end
      endcase
    end
    staged_words[staged_words.size() - 1].last = 1'b1;
    foreach (staged_words[i]) expected_words.push_back(staged_words[i]);
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("word %0d field %s: expected 0x%0h, got 0x%0h", words_seen, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin : drive
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expand_request(offered_req);
        reqs_accepted++;
        if (offered_req.cmd == lcdx_pkg::CMD_INIT) inits_sent++;
        offer = 1'b0;
        if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain_first && expected_words.size() != 0)) begin
          offered_req = pending_reqs.pop_front();
          offer = 1'b1;
          cmd <= offered_req.cmd;
          row <= offered_req.row;
          col <= offered_req.col;
          char_code <= offered_req.char_code;
          light_on <= offered_req.light_on;
        end
      end
      in_valid <= offer;
      quiet_tail <= (pending_reqs.size() < TAIL_REQS);
    end
  end

  // word monitor and output back-pressure
  always @(posedge clk) begin : watch
    lcd_word_t exp_w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("word %0d arrived with nothing expected (byte 0x%0h)",
                 words_seen, expander_byte);
          mismatches++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("byte_valid", exp_w.byte_valid, byte_valid);
          check_field("expander_byte", exp_w.expander_byte, expander_byte);
          check_field("wait_before_ms", exp_w.wait_before_ms, wait_before_ms);
          check_field("wait_after_ms", exp_w.wait_after_ms, wait_after_ms);
          check_field("status", exp_w.status, status);
          check_field("last", exp_w.last, last);
        end
        // long hold so the internal queue fills and the input stalls
        if (words_seen == LONG_HOLD_AT) begin
          recv_stall = LONG_HOLD_CYCLES;
          long_hold_done = 1'b1;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
          $error("no handshake for %0d cycles, %0d words still expected",
                 IDLE_LIMIT, expected_words.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int sel;
    lcd_request_t req;

    // requests before init: not-initialized status, backlight left alone; unused codes give a plain empty result
    add_request(lcdx_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CURSOR, 8'd1, 8'd5, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CHAR, 8'd0, 8'd0, 8'hFF, 1'b1);
    add_request(lcdx_pkg::CMD_BACKLIGHT, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_BACKLIGHT, 8'd0, 8'd0, 8'h00, 1'b1);
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
      add_request(c[2:0], 8'hFF, 8'hFF, 8'hFF, 1'b1);
    // init, then init again once ready
    add_request(lcdx_pkg::CMD_INIT, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_INIT, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    add_request(lcdx_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    // cursor clamp corners
    add_request(lcdx_pkg::CMD_CURSOR, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CURSOR, 8'd1, 8'd15, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CURSOR, 8'd2, 8'd16, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CURSOR, 8'hFF, 8'hFF, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CHAR, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CHAR, 8'd0, 8'd0, 8'hFF, 1'b0);
    add_request(lcdx_pkg::CMD_CHAR, 8'd0, 8'd0, 8'hA5, 1'b0);
    // backlight off must drop BL from later bytes until it is turned back on
    add_request(lcdx_pkg::CMD_BACKLIGHT, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CHAR, 8'd0, 8'd0, 8'h5A, 1'b0);
    add_request(lcdx_pkg::CMD_CURSOR, 8'd1, 8'd200, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'h00, 1'b0);
    add_request(lcdx_pkg::CMD_BACKLIGHT, 8'd0, 8'd0, 8'h00, 1'b1);
    add_request(CMD_LAST_UNUSED, 8'd0, 8'd0, 8'h00, 1'b0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(0, 99);
      req.row = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 2));
      req.col = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 17));
      req.char_code = 8'($urandom_range(0, 255));
      req.light_on = 1'($urandom_range(0, 1));
      req.drain_first = (i == DRAIN_PAUSE_AT);
      if (sel < 32)      req.cmd = lcdx_pkg::CMD_CHAR;
      else if (sel < 54) req.cmd = lcdx_pkg::CMD_CURSOR;
      else if (sel < 68) req.cmd = lcdx_pkg::CMD_CLEAR;
      else if (sel < 90) req.cmd = lcdx_pkg::CMD_BACKLIGHT;
      else if (sel < 96) req.cmd = lcdx_pkg::CMD_INIT;
      else               req.cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      pending_reqs.push_back(req);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d init) and checked %0d expander words.",
             reqs_accepted, inits_sent, words_seen);
    $display("Long output hold %0s, %0d mismatches.",
             long_hold_done ? "exercised" : "not reached", mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
